>>> src/assert_macros.svh
// Assertion macros shared by the controller RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define IPID_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define IPID_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define IPID_ASSERT(label, prop, msg)
`define IPID_NEVER(label, cond, msg)
`endif
`endif

>>> src/ipid_pkg.sv
// Types and constants of the incremental PID controller
`default_nettype none

package ipid_pkg;

    localparam int SAMPLE_WIDTH    = 16;
    localparam int FRAC_BITS       = 8;
    localparam int GAIN_WIDTH      = 16;
    localparam int ERR_WIDTH       = SAMPLE_WIDTH + 1;
    localparam int D1_WIDTH        = ERR_WIDTH + 1;
    localparam int D2_WIDTH        = ERR_WIDTH + 2;
    localparam int PROD_P_WIDTH    = GAIN_WIDTH + D1_WIDTH;
    localparam int PROD_I_WIDTH    = GAIN_WIDTH + ERR_WIDTH;
    localparam int PROD_D_WIDTH    = GAIN_WIDTH + D2_WIDTH;
    localparam int DELTA_WIDTH     = PROD_D_WIDTH + 2;
    localparam int ACC_WIDTH       = SAMPLE_WIDTH + FRAC_BITS;
    localparam int ACC_SUM_WIDTH   = DELTA_WIDTH + 1;
    localparam int ERR_SUM_WIDTH   = ERR_WIDTH + 1;
    localparam int QUEUE_DEPTH     = 8;
    localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);
    localparam int CREDIT_WIDTH    = QUEUE_AW + 1;
    localparam int CFG_INDEX_WIDTH = 3;

    // error sum limit: trunc(drive_max * 4 / 5) via reciprocal multiply
    localparam int LIMIT_MAG_WIDTH = SAMPLE_WIDTH + 3;
    localparam int RECIP_SHIFT     = SAMPLE_WIDTH + 5;
    localparam int RECIP_WIDTH     = RECIP_SHIFT;
    localparam logic [RECIP_WIDTH-1:0] RECIP_FIFTH =
        RECIP_WIDTH'(((2 ** RECIP_SHIFT) + 4) / 5);

    localparam int GAIN_P_RESET    = 256;
    localparam int GAIN_I_RESET    = 0;
    localparam int GAIN_D_RESET    = 0;
    localparam int DRIVE_MIN_RESET = -(2 ** (SAMPLE_WIDTH - 1));
    localparam int DRIVE_MAX_RESET = (2 ** (SAMPLE_WIDTH - 1)) - 1;
    localparam int LIMIT_RESET     = (DRIVE_MAX_RESET * 4) / 5;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_GAIN_P    = 3'd0,
        REG_GAIN_I    = 3'd1,
        REG_GAIN_D    = 3'd2,
        REG_DRIVE_MIN = 3'd3,
        REG_DRIVE_MAX = 3'd4
    } cfg_index_t;

    typedef enum logic {
        OP_COMPUTE = 1'b0,
        OP_CLEAR   = 1'b1
    } op_t;

    typedef struct packed {
        op_t                            op;
        logic signed [SAMPLE_WIDTH-1:0] target;
        logic signed [SAMPLE_WIDTH-1:0] measured;
    } cmd_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] drive;
        logic signed [SAMPLE_WIDTH-1:0] error_sum;
        logic                           clamped;
    } res_t;

    typedef struct packed {
        logic signed [GAIN_WIDTH-1:0] gain_p;
        logic signed [GAIN_WIDTH-1:0] gain_i;
        logic signed [GAIN_WIDTH-1:0] gain_d;
    } gains_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] drive_min;
        logic signed [SAMPLE_WIDTH-1:0] drive_max;
        logic signed [SAMPLE_WIDTH-1:0] err_limit;
    } limits_t;

    typedef struct packed {
        op_t                           op;
        logic signed [ERR_WIDTH-1:0]   err;
        logic signed [DELTA_WIDTH-1:0] delta;
    } work_t;

endpackage

`default_nettype wire

>>> src/ipid_front.sv
// Front end: accepts transactions, tracks error history and forms the increment
`default_nettype none
`include "assert_macros.svh"

module ipid_front
    import ipid_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   cmd_valid,
    output logic   cmd_ready,
    input  cmd_t   cmd,
    input  gains_t gains,
    output logic   push,
    output work_t  push_data,
    input  logic   pop
);

    logic                          accept;
    logic signed [ERR_WIDTH-1:0]   err_w;
    logic signed [D1_WIDTH-1:0]    d1_w;
    logic signed [D2_WIDTH-1:0]    d2_w;

    logic [CREDIT_WIDTH-1:0]       credit_reg, credit_next;
    logic signed [ERR_WIDTH-1:0]   e1_reg, e1_next;
    logic signed [ERR_WIDTH-1:0]   e2_reg, e2_next;

    logic                          s1_valid_reg;
    op_t                           s1_op_reg;
    logic signed [ERR_WIDTH-1:0]   s1_err_reg;
    logic signed [D1_WIDTH-1:0]    s1_d1_reg;
    logic signed [D2_WIDTH-1:0]    s1_d2_reg;

    logic signed [PROD_P_WIDTH-1:0] prod_p;
    logic signed [PROD_I_WIDTH-1:0] prod_i;
    logic signed [PROD_D_WIDTH-1:0] prod_d;

    logic                           s2_valid_reg;
    op_t                            s2_op_reg;
    logic signed [ERR_WIDTH-1:0]    s2_err_reg;
    logic signed [PROD_P_WIDTH-1:0] s2_p_reg;
    logic signed [PROD_I_WIDTH-1:0] s2_i_reg;
    logic signed [PROD_D_WIDTH-1:0] s2_d_reg;

    logic signed [DELTA_WIDTH-1:0]  delta_next;
    logic                           s3_valid_reg;
    work_t                          s3_reg;

    assign accept    = cmd_valid && cmd_ready;
    assign cmd_ready = (credit_reg < CREDIT_WIDTH'(QUEUE_DEPTH));

    assign err_w = ERR_WIDTH'(cmd.target) - ERR_WIDTH'(cmd.measured);
    assign d1_w  = D1_WIDTH'(err_w) - D1_WIDTH'(e1_reg);
    assign d2_w  = D2_WIDTH'(err_w) - (D2_WIDTH'(e1_reg) <<< 1) + D2_WIDTH'(e2_reg);

    always_comb
    begin
        credit_next = credit_reg;
        if (accept && !pop)
        begin
            credit_next = credit_reg + 1'b1;
        end
        else if (!accept && pop)
        begin
            credit_next = credit_reg - 1'b1;
        end

        e1_next = e1_reg;
        e2_next = e2_reg;
        if (accept)
        begin
            if (cmd.op == OP_CLEAR)
            begin
                e1_next = '0;
                e2_next = '0;
            end
            else
            begin
                e1_next = err_w;
                e2_next = e1_reg;
            end
        end
    end

    assign prod_p = gains.gain_p * s1_d1_reg;
    assign prod_i = gains.gain_i * s1_err_reg;
    assign prod_d = gains.gain_d * s1_d2_reg;

    assign delta_next = DELTA_WIDTH'(s2_p_reg) + DELTA_WIDTH'(s2_i_reg)
                      + DELTA_WIDTH'(s2_d_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg   <= '0;
            e1_reg       <= '0;
            e2_reg       <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            credit_reg   <= credit_next;
            e1_reg       <= e1_next;
            e2_reg       <= e2_next;
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_op_reg   <= cmd.op;
        s1_err_reg  <= err_w;
        s1_d1_reg   <= d1_w;
        s1_d2_reg   <= d2_w;

        s2_op_reg   <= s1_op_reg;
        s2_err_reg  <= s1_err_reg;
        s2_p_reg    <= prod_p;
        s2_i_reg    <= prod_i;
        s2_d_reg    <= prod_d;

        s3_reg.op    <= s2_op_reg;
        s3_reg.err   <= s2_err_reg;
        s3_reg.delta <= delta_next;
    end

    assign push      = s3_valid_reg;
    assign push_data = s3_reg;

    `IPID_NEVER(a_credit_overrun, credit_reg > CREDIT_WIDTH'(QUEUE_DEPTH), "credit count overrun")

endmodule

`default_nettype wire

>>> src/ipid_queue.sv
// Queue between the front end and the back end
`default_nettype none
`include "assert_macros.svh"

module ipid_queue
    import ipid_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  work_t push_data,
    input  logic  pop,
    output logic  pop_valid,
    output work_t pop_data
);

    work_t                   entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CREDIT_WIDTH-1:0] count_reg, count_next;

    assign pop_valid = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `IPID_NEVER(a_queue_overflow, push && !pop && count_reg == CREDIT_WIDTH'(QUEUE_DEPTH), "queue overflow")
    `IPID_NEVER(a_queue_underflow, pop && count_reg == '0, "queue underflow")

endmodule

`default_nettype wire

>>> src/ipid_back.sv
// Back end: accumulates the increment, clamps and drives the result register
`default_nettype none
`include "assert_macros.svh"

module ipid_back
    import ipid_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_valid,
    input  work_t   q_data,
    output logic    pop,
    input  limits_t limits,
    output logic    res_valid,
    input  logic    res_ready,
    output res_t    res
);

    logic signed [ACC_WIDTH-1:0]       accum_reg, accum_next;
    logic signed [SAMPLE_WIDTH-1:0]    sum_reg, sum_next;
    logic                              res_valid_reg, res_valid_next;
    res_t                              res_reg, res_next;

    logic signed [ACC_SUM_WIDTH-1:0]   acc_raw;
    logic signed [ACC_WIDTH-1:0]       hi_w, lo_w;
    logic signed [ACC_WIDTH-1:0]       acc_clamped;
    logic                              hit;
    logic signed [ERR_SUM_WIDTH-1:0]   sum_raw, lim_pos, lim_neg;
    logic signed [SAMPLE_WIDTH-1:0]    sum_clamped;

    assign pop = q_valid && (!res_valid_reg || res_ready);

    assign hi_w    = ACC_WIDTH'(limits.drive_max) <<< FRAC_BITS;
    assign lo_w    = ACC_WIDTH'(limits.drive_min) <<< FRAC_BITS;
    assign acc_raw = ACC_SUM_WIDTH'(accum_reg) + ACC_SUM_WIDTH'(q_data.delta);

    assign sum_raw = ERR_SUM_WIDTH'(sum_reg) + ERR_SUM_WIDTH'(q_data.err);
    assign lim_pos = ERR_SUM_WIDTH'(limits.err_limit);
    assign lim_neg = -lim_pos;

    always_comb
    begin
        hit         = 1'b0;
        acc_clamped = acc_raw[ACC_WIDTH-1:0];
        if (acc_raw > ACC_SUM_WIDTH'(hi_w))
        begin
            acc_clamped = hi_w;
            hit         = 1'b1;
        end
        else if (acc_raw < ACC_SUM_WIDTH'(lo_w))
        begin
            acc_clamped = lo_w;
            hit         = 1'b1;
        end

        sum_clamped = sum_raw[SAMPLE_WIDTH-1:0];
        if (sum_raw > lim_pos)
        begin
            sum_clamped = lim_pos[SAMPLE_WIDTH-1:0];
        end
        else if (sum_raw < lim_neg)
        begin
            sum_clamped = lim_neg[SAMPLE_WIDTH-1:0];
        end

        accum_next     = accum_reg;
        sum_next       = sum_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !res_ready;

        if (pop)
        begin
            res_valid_next = 1'b1;
            if (q_data.op == OP_CLEAR)
            begin
                accum_next = '0;
                sum_next   = '0;
                res_next   = '0;
            end
            else
            begin
                accum_next         = acc_clamped;
                sum_next           = sum_clamped;
                res_next.drive     = acc_clamped[ACC_WIDTH-1 -: SAMPLE_WIDTH];
                res_next.error_sum = sum_clamped;
                res_next.clamped   = hit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg     <= '0;
            sum_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            accum_reg     <= accum_next;
            sum_reg       <= sum_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `IPID_ASSERT(a_clear_zeroes, pop && q_data.op == OP_CLEAR |=> accum_reg == '0 && sum_reg == '0, "clear left state")
    `IPID_ASSERT(a_pop_loads, pop |=> res_valid_reg, "popped transaction not presented")

endmodule

`default_nettype wire

>>> src/incremental_pid_controller.sv
// Top level of the incremental PID controller
//
//  channel   direction  handshake              payload
//  cmd       in         cmd_valid / cmd_ready  cmd_t  (op, target, measured)
//  res       out        res_valid / res_ready  res_t  (drive, error_sum, clamped)
//  cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  One transaction per cycle sustained while cmd_ready stays high and res_ready does not stall results.
//  Each passes three front stages (difference, gain multiply, increment sum), the queue
//  and the result register; the back end closes the accumulator loop each cycle.
//  cmd_ready drops only when eight transactions are outstanding in front and queue.
//  Reset clears history, accumulator, error sum and all valid state; no clearing pass.
`default_nettype none

module incremental_pid_controller
    import ipid_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    output logic                       cmd_ready,
    input  cmd_t                       cmd,
    output logic                       res_valid,
    input  logic                       res_ready,
    output res_t                       res,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [SAMPLE_WIDTH-1:0]    cfg_data
);

    gains_t                        gains_reg, gains_next;
    limits_t                       limits_reg, limits_next;
    logic                          cfg_write;

    logic [SAMPLE_WIDTH:0]                       max_mag;
    logic [LIMIT_MAG_WIDTH-1:0]                  max_mag4;
    logic [LIMIT_MAG_WIDTH+RECIP_WIDTH-1:0]      fifth_prod;
    logic [SAMPLE_WIDTH-1:0]                     fifth_mag;
    logic [SAMPLE_WIDTH-1:0]                     limit_w;

    logic  push;
    work_t push_data;
    logic  q_valid;
    work_t q_data;
    logic  pop;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    assign max_mag    = cfg_data[SAMPLE_WIDTH-1]
                      ? ((SAMPLE_WIDTH+1)'(0) - {1'b1, cfg_data})
                      : {1'b0, cfg_data};
    assign max_mag4   = {max_mag, 2'b00};
    assign fifth_prod = max_mag4 * RECIP_FIFTH;
    assign fifth_mag  = fifth_prod[RECIP_SHIFT +: SAMPLE_WIDTH];
    assign limit_w    = cfg_data[SAMPLE_WIDTH-1] ? (SAMPLE_WIDTH'(0) - fifth_mag) : fifth_mag;

    always_comb
    begin
        gains_next  = gains_reg;
        limits_next = limits_reg;
        if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_GAIN_P:    gains_next.gain_p = cfg_data;
                REG_GAIN_I:    gains_next.gain_i = cfg_data;
                REG_GAIN_D:    gains_next.gain_d = cfg_data;
                REG_DRIVE_MIN: limits_next.drive_min = cfg_data;
                REG_DRIVE_MAX:
                begin
                    limits_next.drive_max = cfg_data;
                    limits_next.err_limit = limit_w;
                end
                default:
                begin
                    gains_next  = gains_reg;
                    limits_next = limits_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg.gain_p      <= GAIN_WIDTH'(GAIN_P_RESET);
            gains_reg.gain_i      <= GAIN_WIDTH'(GAIN_I_RESET);
            gains_reg.gain_d      <= GAIN_WIDTH'(GAIN_D_RESET);
            limits_reg.drive_min  <= SAMPLE_WIDTH'(DRIVE_MIN_RESET);
            limits_reg.drive_max  <= SAMPLE_WIDTH'(DRIVE_MAX_RESET);
            limits_reg.err_limit  <= SAMPLE_WIDTH'(LIMIT_RESET);
        end
        else
        begin
            gains_reg  <= gains_next;
            limits_reg <= limits_next;
        end
    end

    ipid_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .gains     (gains_reg),
        .push      (push),
        .push_data (push_data),
        .pop       (pop)
    );

    ipid_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_valid (q_valid),
        .pop_data  (q_data)
    );

    ipid_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .pop       (pop),
        .limits    (limits_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule

`default_nettype wire

>>> tb/ipid_checker.sv
// Checker for the incremental PID controller: models the control law and compares results
module ipid_checker
    import ipid_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    input  logic                       cmd_ready,
    input  cmd_t                       cmd,
    input  logic                       res_valid,
    input  logic                       res_ready,
    input  res_t                       res,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [SAMPLE_WIDTH-1:0]    cfg_data,
    output int                         fail_count,
    output int                         outstanding,
    output int                         checked,
    output int                         clamp_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [GAIN_WIDTH-1:0]   kp;
    logic signed [GAIN_WIDTH-1:0]   ki;
    logic signed [GAIN_WIDTH-1:0]   kd;
    logic signed [SAMPLE_WIDTH-1:0] lo_lim;
    logic signed [SAMPLE_WIDTH-1:0] hi_lim;
    logic signed [ERR_WIDTH-1:0]    err_prev;
    logic signed [ERR_WIDTH-1:0]    err_prev2;
    logic signed [ACC_WIDTH-1:0]    accum;
    logic signed [SAMPLE_WIDTH-1:0] err_total;
    res_t                           drive_queue[$];
    int                             errors;
    int                             n_checked;
    int                             n_clamped;

    function automatic res_t step_controller(input cmd_t c);
        res_t   r;
        longint e;
        longint delta;
        longint acc;
        longint upper;
        longint lower;
        longint lim;
        longint total;
        r = '0;
        if (c.op == OP_CLEAR) begin
            err_prev  = '0;
            err_prev2 = '0;
            accum     = '0;
            err_total = '0;
            return r;
        end
        e = longint'(c.target) - longint'(c.measured);
        delta = longint'(kp) * (e - longint'(err_prev))
              + longint'(ki) * e
              + longint'(kd) * (e - 2 * longint'(err_prev) + longint'(err_prev2));
        acc   = longint'(accum) + delta;
        upper = longint'(hi_lim) * (longint'(1) << FRAC_BITS);
        lower = longint'(lo_lim) * (longint'(1) << FRAC_BITS);
        if (acc > upper) begin
            acc       = upper;
            r.clamped = 1'b1;
        end
        else if (acc < lower) begin
            acc       = lower;
            r.clamped = 1'b1;
        end
        accum = acc[ACC_WIDTH-1:0];
        lim   = (longint'(hi_lim) * 4) / 5;
        total = longint'(err_total) + e;
        if (total > lim)
            total = lim;
        else if (total < -lim)
            total = -lim;
        err_total   = total[SAMPLE_WIDTH-1:0];
        err_prev2   = err_prev;
        err_prev    = e[ERR_WIDTH-1:0];
        r.drive     = acc[FRAC_BITS +: SAMPLE_WIDTH];
        r.error_sum = err_total;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        res_t want;
        if (!rst_n)
        begin
            kp          = GAIN_WIDTH'(GAIN_P_RESET);
            ki          = GAIN_WIDTH'(GAIN_I_RESET);
            kd          = GAIN_WIDTH'(GAIN_D_RESET);
            lo_lim      = SAMPLE_WIDTH'(DRIVE_MIN_RESET);
            hi_lim      = SAMPLE_WIDTH'(DRIVE_MAX_RESET);
            err_prev    = '0;
            err_prev2   = '0;
            accum       = '0;
            err_total   = '0;
            drive_queue.delete();
            errors      = 0;
            n_checked   = 0;
            n_clamped   = 0;
            fail_count  <= 0;
            outstanding <= 0;
            checked     <= 0;
            clamp_hits  <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_GAIN_P:    kp     = cfg_data;
                    REG_GAIN_I:    ki     = cfg_data;
                    REG_GAIN_D:    kd     = cfg_data;
                    REG_DRIVE_MIN: lo_lim = cfg_data;
                    REG_DRIVE_MAX: hi_lim = cfg_data;
                    default:       ;
                endcase
            end
            if (cmd_valid && cmd_ready)
            begin
                want = step_controller(cmd);
                if (want.clamped)
                    n_clamped++;
                drive_queue.push_back(want);
            end
            if (res_valid && res_ready)
            begin
                if (drive_queue.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result drive %0d error_sum %0d clamped %0b",
                             $time, res.drive, res.error_sum, res.clamped);
                end
                else
                begin
                    want = drive_queue.pop_front();
                    n_checked++;
                    if (res.drive !== want.drive)
                    begin
                        errors++;
                        $display("%0t: drive expected %0d, actual %0d",
                                 $time, want.drive, res.drive);
                    end
                    if (res.error_sum !== want.error_sum)
                    begin
                        errors++;
                        $display("%0t: error_sum expected %0d, actual %0d",
                                 $time, want.error_sum, res.error_sum);
                    end
                    if (res.clamped !== want.clamped)
                    begin
                        errors++;
                        $display("%0t: clamped expected %0b, actual %0b",
                                 $time, want.clamped, res.clamped);
                    end
                end
            end
            fail_count  <= errors;
            outstanding <= drive_queue.size();
            checked     <= n_checked;
            clamp_hits  <= n_clamped;
        end
    end

endmodule

>>> tb/testbench.sv
// Top of the incremental PID controller testbench: clock, reset, stimulus and verdict
module testbench;
    import ipid_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int LATENCY      = 5;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 88;
    localparam int STEADY_PHASE = 2;

    logic                       clk;
    logic                       rst_n;
    logic                       cmd_valid;
    logic                       cmd_ready;
    cmd_t                       cmd;
    logic                       res_valid;
    logic                       res_ready;
    res_t                       res;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [SAMPLE_WIDTH-1:0]    cfg_data;
    int                         fail_count;
    int                         outstanding;
    int                         checked;
    int                         clamp_hits;
    int                         cycles;
    logic                       steady;
    int                         n_items;
    int                         n_clears;
    int                         n_writes;
    int                         n_settings;

    incremental_pid_controller u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ipid_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .checked     (checked),
        .clamp_hits  (clamp_hits)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
        res_ready <= steady || ($urandom_range(0, 99) >= 25);

    task automatic issue_sample(input op_t op, input logic [15:0] tgt,
                                input logic [15:0] meas);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(0, 99) < 25)
            gap = $urandom_range(1, 3);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid    <= 1'b1;
        cmd.op       <= op;
        cmd.target   <= tgt;
        cmd.measured <= meas;
        do @(posedge clk); while (!cmd_ready);
        n_items++;
        if (op == OP_CLEAR)
            n_clears++;
    endtask

    task automatic wait_idle();
        cmd_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [SAMPLE_WIDTH-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        n_writes++;
    endtask

    task automatic load_settings(input logic [15:0] kp, input logic [15:0] ki,
                                 input logic [15:0] kd, input logic [15:0] lo,
                                 input logic [15:0] hi);
        write_reg(CFG_INDEX_WIDTH'($urandom_range(int'(REG_DRIVE_MAX) + 1,
                                                  (1 << CFG_INDEX_WIDTH) - 1)),
                  16'($urandom));
        write_reg(REG_GAIN_P, kp);
        write_reg(REG_GAIN_I, ki);
        write_reg(REG_GAIN_D, kd);
        write_reg(REG_DRIVE_MIN, lo);
        write_reg(REG_DRIVE_MAX, hi);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom);
            1:       return 16'(int'($urandom_range(0, 1024)) - 512);
            2:       return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            default: return $urandom_range(0, 1) ? 16'd256 : 16'd0;
        endcase
    endfunction

    function automatic logic [15:0] pick_extreme();
        case ($urandom_range(0, 3))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            default: return 16'hffff;
        endcase
    endfunction

    initial
    begin : stimulus
        logic [15:0] lo;
        logic [15:0] hi;
        int          span;
        int          setpoint;
        int          kind;
        rst_n      = 1'b0;
        cmd_valid  = 1'b0;
        cmd        = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        res_ready  = 1'b0;
        steady     = 1'b0;
        cycles     = 0;
        n_items    = 0;
        n_clears   = 0;
        n_writes   = 0;
        n_settings = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue_sample(OP_COMPUTE, 16'h7fff, 16'h8000);
        issue_sample(OP_COMPUTE, 16'h8000, 16'h7fff);
        issue_sample(OP_COMPUTE, 16'd0, 16'd0);
        issue_sample(OP_COMPUTE, 16'hffff, 16'd0);
        issue_sample(OP_CLEAR, 16'h1234, 16'h4321);
        issue_sample(OP_COMPUTE, 16'd100, 16'hff9c);
        issue_sample(OP_COMPUTE, 16'd0, 16'd1);
        wait_idle();
        load_settings(16'h7fff, 16'h8000, 16'h7fff, 16'hff9c, 16'd100);
        issue_sample(OP_COMPUTE, 16'h7fff, 16'h8000);
        issue_sample(OP_COMPUTE, 16'h8000, 16'h7fff);
        issue_sample(OP_COMPUTE, 16'h8000, 16'h8000);
        issue_sample(OP_COMPUTE, 16'd5, 16'd3);
        issue_sample(OP_CLEAR, 16'hffff, 16'hffff);
        wait_idle();
        // crossed limits with a negative upper limit
        load_settings(16'h8000, 16'h7fff, 16'h8000, 16'd50, 16'hffce);
        issue_sample(OP_COMPUTE, 16'd10, 16'd0);
        issue_sample(OP_COMPUTE, 16'hfff6, 16'd0);
        issue_sample(OP_CLEAR, 16'd0, 16'd0);
        issue_sample(OP_COMPUTE, 16'h7fff, 16'h8000);
        issue_sample(OP_COMPUTE, 16'd0, 16'd0);
        wait_idle();
        load_settings(16'd256, 16'd16, 16'd64, 16'h8000, 16'h8000);
        issue_sample(OP_COMPUTE, 16'd1, 16'd0);
        issue_sample(OP_COMPUTE, 16'hfc18, 16'd0);
        issue_sample(OP_COMPUTE, 16'h7fff, 16'h7fff);
        wait_idle();
        load_settings(16'd0, 16'd0, 16'd0, 16'h7fff, 16'h7fff);
        issue_sample(OP_COMPUTE, 16'hfffb, 16'd5);
        issue_sample(OP_CLEAR, 16'd0, 16'd0);
        issue_sample(OP_COMPUTE, 16'd0, 16'd0);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            steady <= (ph == STEADY_PHASE);
            case ($urandom_range(0, 4))
                0:
                begin
                    lo = 16'h8000;
                    hi = 16'h7fff;
                end
                1:
                begin
                    span = $urandom_range(1, 2000);
                    lo   = 16'(-span);
                    hi   = 16'(span);
                end
                2:
                begin
                    lo = 16'($urandom_range(0, 3000));
                    hi = 16'(-int'($urandom_range(0, 3000)));
                end
                3:
                begin
                    lo = 16'($urandom);
                    hi = 16'($urandom);
                end
                default:
                begin
                    hi = 16'(-int'($urandom_range(1, 500)));
                    lo = 16'(int'(signed'(hi)) - int'($urandom_range(0, 500)));
                end
            endcase
            load_settings(pick_gain(), pick_gain(), pick_gain(), lo, hi);
            setpoint = int'($urandom_range(0, 60000)) - 30000;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                kind = $urandom_range(0, 99);
                if ($urandom_range(0, 99) == 0)
                    wait_idle();
                if ($urandom_range(0, 19) == 0)
                    setpoint = int'($urandom_range(0, 60000)) - 30000;
                if (kind < 4)
                    issue_sample(OP_CLEAR, 16'($urandom), 16'($urandom));
                else if (kind < 14)
                    issue_sample(OP_COMPUTE, 16'($urandom), 16'($urandom));
                else if (kind < 20)
                    issue_sample(OP_COMPUTE, pick_extreme(), pick_extreme());
                else
                    issue_sample(OP_COMPUTE, 16'(setpoint),
                                 16'(setpoint + int'($urandom_range(0, 400)) - 200));
            end
        end

        wait_idle();
        steady <= 1'b0;
        repeat (4 * LATENCY) @(posedge clk);
        $display("Ran %0d commands (%0d history clears) over %0d register settings, %0d writes.",
                 n_items, n_clears, n_settings, n_writes);
        $display("Compared %0d results, %0d of them with the drive forced to a limit.",
                 checked, clamp_hits);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/ipid_pkg.sv
src/ipid_front.sv
src/ipid_queue.sv
src/ipid_back.sv
src/incremental_pid_controller.sv
tb/ipid_checker.sv
tb/testbench.sv
